### sv/ansi_text_terminal_cursor_core_assert.svh
// Assertion macros for the ANSI text terminal cursor core checker
`ifndef ANSI_TEXT_TERMINAL_CURSOR_CORE_ASSERT_SVH
`define ANSI_TEXT_TERMINAL_CURSOR_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ATC_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atc check failed");

// antecedent implies consequent in the next cycle
`define ATC_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atc check failed");

`endif

### sv/atc_pkg.sv
// Shared types, constants and codes of the ANSI text terminal cursor core
package atc_pkg;

    localparam int COORD_BITS_DEF = 8;
    localparam int APB_ADDR_BITS  = 4;
    localparam int APB_DATA_BITS  = 32;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_M        = 8'h6D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;

    localparam logic [9:0] CODE_RESET = 10'd0;
    localparam logic [9:0] CODE_FG_LO = 10'd30;
    localparam logic [9:0] CODE_FG_HI = 10'd37;
    localparam logic [9:0] CODE_BG_LO = 10'd40;
    localparam logic [9:0] CODE_BG_HI = 10'd47;
    localparam logic [9:0] CODE_MAX   = 10'd999;

    localparam logic [3:0] FORE_DEFAULT = 4'd8;
    localparam logic [2:0] BACK_DEFAULT = 3'd0;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;
    localparam logic [4:0] TAB_RESET  = 5'd8;

    localparam logic [1:0] REG_GRID_COLUMNS = 2'd0;
    localparam logic [1:0] REG_GRID_ROWS    = 2'd1;
    localparam logic [1:0] REG_TAB_STOP     = 2'd2;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_SCROLL = 1'b1;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_ESC    = 2'd1,
        PH_CSI    = 2'd2
    } esc_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIVIDE,
        ST_TABFIX,
        ST_WRAP,
        ST_EMIT_DRAW,
        ST_EMIT_SCROLL
    } ctrl_state_t;

    typedef struct packed {
        logic [7:0] grid_columns;
        logic [7:0] grid_rows;
        logic [4:0] tab_stop;
    } cfg_t;

    typedef struct packed {
        logic [3:0] fore;
        logic [2:0] back;
    } colour_t;

    typedef struct packed {
        logic load_byte;
        logic decode;
        logic div_step;
        logic tab_fix;
        logic wrap;
        logic emit_draw;
        logic emit_scroll;
    } ctrl_cmd_t;

    typedef struct packed {
        logic consumed;
        logic is_tab;
        logic div_last;
        logic draw_pending;
        logic scroll_now;
        logic scroll_pending;
        logic out_free;
    } dp_status_t;

endpackage

### sv/atc_regs.sv
// APB configuration registers of the ANSI text terminal cursor core
module atc_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [atc_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [atc_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [atc_pkg::APB_DATA_BITS-1:0]    prdata,
    output atc_pkg::cfg_t                        cfg
);
    import atc_pkg::*;

    logic [7:0] cols_reg;
    logic [7:0] rows_reg;
    logic [4:0] tab_reg;
    logic       wr_en;
    logic [1:0] reg_index;

    assign wr_en     = psel & penable & pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
            tab_reg  <= TAB_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_GRID_COLUMNS: cols_reg <= pwdata[7:0];
                REG_GRID_ROWS:    rows_reg <= pwdata[7:0];
                REG_TAB_STOP:     tab_reg  <= pwdata[4:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_GRID_COLUMNS: prdata = APB_DATA_BITS'(cols_reg);
            REG_GRID_ROWS:    prdata = APB_DATA_BITS'(rows_reg);
            REG_TAB_STOP:     prdata = APB_DATA_BITS'(tab_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.grid_columns = cols_reg;
    assign cfg.grid_rows    = rows_reg;
    assign cfg.tab_stop     = tab_reg;

endmodule

### sv/atc_ctrl.sv
// Sequencing state machine of the ANSI text terminal cursor core
module atc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  atc_pkg::dp_status_t status,
    output atc_pkg::ctrl_cmd_t  cmd
);
    import atc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (char_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                if (status.consumed)
                    state_next = ST_IDLE;
                else if (status.is_tab)
                    state_next = ST_DIVIDE;
                else
                    state_next = ST_WRAP;
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                    state_next = ST_TABFIX;
            end
            ST_TABFIX:
                state_next = ST_WRAP;
            ST_WRAP:
            begin
                if (status.draw_pending)
                    state_next = ST_EMIT_DRAW;
                else if (status.scroll_now)
                    state_next = ST_EMIT_SCROLL;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT_DRAW:
            begin
                if (status.out_free)
                    state_next = status.scroll_pending ? ST_EMIT_SCROLL : ST_IDLE;
            end
            ST_EMIT_SCROLL:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        char_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                char_stall    = 1'b0;
                cmd.load_byte = char_valid;
            end
            ST_DECODE:      cmd.decode      = 1'b1;
            ST_DIVIDE:      cmd.div_step    = 1'b1;
            ST_TABFIX:      cmd.tab_fix     = 1'b1;
            ST_WRAP:        cmd.wrap        = 1'b1;
            ST_EMIT_DRAW:   cmd.emit_draw   = status.out_free;
            ST_EMIT_SCROLL: cmd.emit_scroll = status.out_free;
            default:        ;
        endcase
    end

endmodule

### sv/atc_dp.sv
// Parser, cursor, tab remainder unit and output word register
module atc_dp #(
    parameter int COORD_BITS = atc_pkg::COORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  atc_pkg::cfg_t       cfg,
    input  atc_pkg::ctrl_cmd_t  cmd,
    output atc_pkg::dp_status_t status,
    input  logic [7:0]          char_byte,
    input  logic                cmd_stall,
    output logic                cmd_valid,
    output logic                command,
    output logic [7:0]          cell_col,
    output logic [7:0]          cell_row,
    output logic [7:0]          glyph,
    output logic [3:0]          fore_index,
    output logic [2:0]          back_index,
    output logic                last_of_run
);
    import atc_pkg::*;

    localparam int CB       = COORD_BITS;
    localparam int WB       = (CB + 1 > 8) ? CB + 1 : 8;
    localparam int CNT_BITS = $clog2(CB);

    function automatic colour_t apply_code(input logic [9:0] code, input colour_t cur);
        colour_t res;
        res = cur;
        if (code == CODE_RESET)
        begin
            res.fore = FORE_DEFAULT;
            res.back = BACK_DEFAULT;
        end
        else if (code >= CODE_FG_LO && code <= CODE_FG_HI)
            res.fore = 4'(code - CODE_FG_LO);
        else if (code >= CODE_BG_LO && code <= CODE_BG_HI)
            res.back = 3'(code - CODE_BG_LO);
        return res;
    endfunction

    // persistent state
    logic [7:0]    byte_reg;
    logic [CB-1:0] cursor_col_reg, cursor_col_next;
    logic [CB-1:0] cursor_row_reg, cursor_row_next;
    colour_t       colour_reg, colour_next;
    esc_phase_t    phase_reg, phase_next;
    logic          digits_reg, digits_next;
    logic [9:0]    code_reg, code_next;

    // working registers of one byte
    logic [WB-1:0]       col_w_reg, col_w_next;
    logic [WB-1:0]       row_w_reg, row_w_next;
    logic                draw_reg, draw_next;
    logic [CB-1:0]       draw_col_reg, draw_col_next;
    logic [CB-1:0]       draw_row_reg;
    logic [7:0]          draw_glyph_reg, draw_glyph_next;
    logic                scroll_reg;
    logic [CB-1:0]       div_shift_reg;
    logic [4:0]          rem_reg, rem_next;
    logic [CNT_BITS-1:0] cnt_reg;

    // output word register
    logic       out_valid_reg, out_valid_next;
    logic       out_cmd_reg;
    logic [7:0] out_col_reg;
    logic [7:0] out_row_reg;
    logic [7:0] out_glyph_reg;
    logic [3:0] out_fore_reg;
    logic [2:0] out_back_reg;
    logic       out_last_reg;

    logic [7:0]    width_eff;
    logic [7:0]    height_eff;
    logic [4:0]    tab_eff;
    logic          consumed;
    logic [13:0]   code_prod;
    logic [5:0]    rem_shift;
    logic          wrap;
    logic [WB-1:0] row_f;
    logic          scroll_now;
    logic [WB-1:0] row_final;
    logic [WB-1:0] draw_col_ext;
    logic [WB-1:0] draw_row_ext;
    logic          out_free;

    assign width_eff  = (cfg.grid_columns == 8'd0) ? 8'd1 : cfg.grid_columns;
    assign height_eff = (cfg.grid_rows == 8'd0) ? 8'd1 : cfg.grid_rows;
    assign tab_eff    = (cfg.tab_stop == 5'd0) ? 5'd1 : cfg.tab_stop;

    assign code_prod = {1'b0, code_reg, 3'b000} + {3'b000, code_reg, 1'b0}
                     + {10'd0, 4'(byte_reg - CH_ZERO)};

    // escape parser
    always_comb
    begin
        phase_next  = phase_reg;
        digits_next = digits_reg;
        code_next   = code_reg;
        colour_next = colour_reg;
        consumed    = 1'b0;
        unique case (phase_reg)
            PH_ESC:
            begin
                if (byte_reg == CH_LBRACKET)
                begin
                    phase_next  = PH_CSI;
                    digits_next = 1'b0;
                    code_next   = CODE_RESET;
                    consumed    = 1'b1;
                end
                else
                    phase_next = PH_NORMAL;
            end
            PH_CSI:
            begin
                consumed = 1'b1;
                if (byte_reg >= CH_ZERO && byte_reg <= CH_NINE)
                begin
                    code_next   = (code_prod > 14'(CODE_MAX)) ? CODE_MAX : code_prod[9:0];
                    digits_next = 1'b1;
                end
                else if (byte_reg == CH_SEMI)
                begin
                    colour_next = apply_code(code_reg, colour_reg);
                    code_next   = CODE_RESET;
                    digits_next = 1'b0;
                end
                else if (byte_reg == CH_M)
                begin
                    colour_next = apply_code(digits_reg ? code_reg : CODE_RESET, colour_reg);
                    phase_next  = PH_NORMAL;
                end
                else
                    phase_next = PH_NORMAL;
            end
            default:
            begin
                phase_next = PH_NORMAL;
                if (byte_reg == CH_ESC)
                begin
                    phase_next = PH_ESC;
                    consumed   = 1'b1;
                end
            end
        endcase
    end

    // cursor move
    always_comb
    begin
        col_w_next      = WB'(cursor_col_reg);
        row_w_next      = WB'(cursor_row_reg);
        draw_next       = 1'b0;
        draw_col_next   = cursor_col_reg;
        draw_glyph_next = byte_reg;
        case (byte_reg)
            CH_BS:
            begin
                if (cursor_col_reg != '0)
                begin
                    col_w_next      = WB'(cursor_col_reg) - WB'(1);
                    draw_next       = 1'b1;
                    draw_col_next   = cursor_col_reg - CB'(1);
                    draw_glyph_next = CH_SPACE;
                end
            end
            CH_CR:  col_w_next = '0;
            CH_TAB: ;
            CH_LF:
            begin
                col_w_next = '0;
                row_w_next = WB'(cursor_row_reg) + WB'(1);
            end
            default:
            begin
                col_w_next = WB'(cursor_col_reg) + WB'(1);
                draw_next  = 1'b1;
            end
        endcase
        if (cmd.tab_fix)
            col_w_next = WB'(cursor_col_reg) - WB'(rem_reg) + WB'(tab_eff);
    end

    // bit-serial remainder of cursor column by tab spacing
    assign rem_shift = {rem_reg, div_shift_reg[CB-1]};
    assign rem_next  = (rem_shift >= {1'b0, tab_eff}) ? 5'(rem_shift - {1'b0, tab_eff})
                                                      : rem_shift[4:0];

    // wrap and scroll
    assign wrap       = col_w_reg >= WB'(width_eff);
    assign row_f      = row_w_reg + WB'(wrap);
    assign scroll_now = row_f >= WB'(height_eff);
    assign row_final  = scroll_now ? WB'(height_eff - 8'd1) : row_f;

    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        if (cmd.wrap)
        begin
            cursor_col_next = wrap ? '0 : col_w_reg[CB-1:0];
            cursor_row_next = row_final[CB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            colour_reg     <= '{fore: FORE_DEFAULT, back: BACK_DEFAULT};
            phase_reg      <= PH_NORMAL;
            digits_reg     <= 1'b0;
            code_reg       <= '0;
            draw_reg       <= 1'b0;
            scroll_reg     <= 1'b0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            if (cmd.decode)
            begin
                colour_reg <= colour_next;
                phase_reg  <= phase_next;
                digits_reg <= digits_next;
                code_reg   <= code_next;
                draw_reg   <= draw_next & ~consumed;
            end
            if (cmd.wrap)
                scroll_reg <= scroll_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte)
            byte_reg <= char_byte;
        if (cmd.decode)
        begin
            draw_col_reg   <= draw_col_next;
            draw_row_reg   <= cursor_row_reg;
            draw_glyph_reg <= draw_glyph_next;
            div_shift_reg  <= cursor_col_reg;
            rem_reg        <= '0;
            cnt_reg        <= CNT_BITS'(CB - 1);
        end
        else if (cmd.div_step)
        begin
            div_shift_reg <= {div_shift_reg[CB-2:0], 1'b0};
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_reg - CNT_BITS'(1);
        end
        if (cmd.decode || cmd.tab_fix)
        begin
            col_w_reg <= col_w_next;
            row_w_reg <= row_w_next;
        end
    end

    // output word register
    assign out_free     = ~out_valid_reg | ~cmd_stall;
    assign draw_col_ext = WB'(draw_col_reg);
    assign draw_row_ext = WB'(draw_row_reg);

    always_comb
    begin
        if (cmd.emit_draw || cmd.emit_scroll)
            out_valid_next = 1'b1;
        else if (!cmd_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_draw)
        begin
            out_cmd_reg   <= CMD_DRAW;
            out_col_reg   <= draw_col_ext[7:0];
            out_row_reg   <= draw_row_ext[7:0];
            out_glyph_reg <= draw_glyph_reg;
            out_fore_reg  <= colour_reg.fore;
            out_back_reg  <= colour_reg.back;
            out_last_reg  <= ~scroll_reg;
        end
        else if (cmd.emit_scroll)
        begin
            out_cmd_reg   <= CMD_SCROLL;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_glyph_reg <= '0;
            out_fore_reg  <= '0;
            out_back_reg  <= colour_reg.back;
            out_last_reg  <= 1'b1;
        end
    end

    assign cmd_valid   = out_valid_reg;
    assign command     = out_cmd_reg;
    assign cell_col    = out_col_reg;
    assign cell_row    = out_row_reg;
    assign glyph       = out_glyph_reg;
    assign fore_index  = out_fore_reg;
    assign back_index  = out_back_reg;
    assign last_of_run = out_last_reg;

    assign status.consumed       = consumed;
    assign status.is_tab         = byte_reg == CH_TAB;
    assign status.div_last       = cnt_reg == '0;
    assign status.draw_pending   = draw_reg;
    assign status.scroll_now     = scroll_now;
    assign status.scroll_pending = scroll_reg;
    assign status.out_free       = out_free;

endmodule

### sv/ansi_text_terminal_cursor_core.sv
// ANSI text terminal cursor core: takes one character byte per word on the char
// channel, strips ESC [ ... m colour sequences (codes 0, 30-37, 40-47, code value
// saturating at 999) and moves a text cursor over a grid of grid_columns by grid_rows
// cells, emitting draw and scroll words on the cmd channel (at most two per byte, a
// draw before a scroll, last_of_run on the final one). One byte is in work at a time;
// the output word register lets the next byte be taken while a word still waits.
// A byte swallowed by the escape parser goes back to idle after decode; CR, LF and
// backspace at column 0 pass the wrap step with no draw word, a drawn byte emits a
// draw word and a scroll adds a scroll word. For a tab the column remainder by
// tab_stop is worked out one bit per cycle in a serial restoring divider before the wrap.
// grid_columns, grid_rows and tab_stop sit at APB byte addresses 0x0, 0x4 and 0x8;
// write them only while the block is idle.
module ansi_text_terminal_cursor_core #(
    parameter int COORD_BITS = atc_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              char_valid,
    output logic                              char_stall,
    input  logic [7:0]                        char_byte,
    output logic                              cmd_valid,
    input  logic                              cmd_stall,
    output logic                              command,
    output logic [7:0]                        cell_col,
    output logic [7:0]                        cell_row,
    output logic [7:0]                        glyph,
    output logic [3:0]                        fore_index,
    output logic [2:0]                        back_index,
    output logic                              last_of_run,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [atc_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [atc_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [atc_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import atc_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign pready = 1'b1;

    atc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    atc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .status     (status),
        .cmd        (cmd)
    );

    atc_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .char_byte   (char_byte),
        .cmd_stall   (cmd_stall),
        .cmd_valid   (cmd_valid),
        .command     (command),
        .cell_col    (cell_col),
        .cell_row    (cell_row),
        .glyph       (glyph),
        .fore_index  (fore_index),
        .back_index  (back_index),
        .last_of_run (last_of_run)
    );

endmodule

### sv/atc_checker.sv
// Port-level checker of the ANSI text terminal cursor core and its bind
`include "ansi_text_terminal_cursor_core_assert.svh"

module atc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       char_valid,
    input logic       char_stall,
    input logic       cmd_valid,
    input logic       cmd_stall,
    input logic       command,
    input logic [7:0] cell_col,
    input logic [7:0] cell_row,
    input logic [7:0] glyph,
    input logic [3:0] fore_index,
    input logic [2:0] back_index,
    input logic       last_of_run
);
    import atc_pkg::*;

    `ATC_CHECK_NEXT(a_cmd_hold, cmd_valid && cmd_stall, cmd_valid && $stable(command) && $stable(cell_col) && $stable(cell_row) && $stable(glyph) && $stable(fore_index) && $stable(back_index) && $stable(last_of_run))
    `ATC_CHECK_NEXT(a_one_byte_in_work, char_valid && !char_stall, char_stall)
    `ATC_CHECK_NOW(a_scroll_fields, cmd_valid && command == CMD_SCROLL, cell_col == 8'd0 && cell_row == 8'd0 && glyph == 8'd0 && fore_index == 4'd0)
    `ATC_CHECK_NOW(a_scroll_last, cmd_valid && command == CMD_SCROLL, last_of_run)

endmodule

bind ansi_text_terminal_cursor_core atc_checker u_atc_checker (.*);
